### rtl/ophist_pkg.sv
// Shared types, constants and helper functions for the ordinal pattern histogram.
`default_nettype none
package ophist_pkg;

  // Table and counter geometry
  localparam int TABLE_DEPTH   = 128;
  localparam int MAX_DIMENSION = 5;
  localparam int COUNT_BITS    = 20;

  // Fixed field widths of the transaction ports
  localparam int ELEM_BITS = 3;
  localparam int OP_W      = 2;
  localparam int ENTRY_W   = 7;
  localparam int PAT_W     = 15;
  localparam int DIM_W     = 3;
  localparam int MATCH_W   = 20;
  localparam int FRAC_BITS = 16;
  localparam int FREQ_W    = FRAC_BITS + 1;

  localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(3);

  // Derived widths
  localparam int CELL_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int NACT_W = $clog2(TABLE_DEPTH + 1);
  localparam int CMP_W  = (ENTRY_W > CELL_W) ? ENTRY_W : CELL_W;
  localparam int STEP_W = $clog2(FRAC_BITS);

  typedef enum logic [OP_W-1:0] {
    OP_LOAD  = 2'd0,
    OP_COUNT = 2'd1,
    OP_READ  = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_RUN,
    DIV_DONE
  } div_state_t;

  // One transaction as it travels down the cell chain
  typedef struct packed {
    logic                  valid;
    op_t                   op;
    logic [ENTRY_W-1:0]    idx;
    logic [PAT_W-1:0]      word;
    logic [COUNT_BITS-1:0] cnt;
  } item_t;

  // Settings broadcast to every cell, derived from the dimension register
  typedef struct packed {
    logic [PAT_W-1:0]  mask;
    logic [NACT_W-1:0] nact;
  } chain_ctl_t;

  // Finished read result
  typedef struct packed {
    logic [ENTRY_W-1:0] idx;
    logic [MATCH_W-1:0] cnt;
    logic [FREQ_W-1:0]  freq;
    logic               none;
  } rd_res_t;

  // Clamp the dimension register into the supported range
  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] d;
    d = v;
    if (d < DIM_W'(2)) d = DIM_W'(2);
    if (d > DIM_W'(MAX_DIMENSION)) d = DIM_W'(MAX_DIMENSION);
    return d;
  endfunction

  // Bit mask covering the first d pattern elements
  function automatic logic [PAT_W-1:0] elem_mask(input logic [DIM_W-1:0] d);
    logic [PAT_W-1:0] m;
    m = '0;
    for (int b = 0; b < PAT_W; b++) begin
      m[b] = ((b / ELEM_BITS) < int'(d));
    end
    return m;
  endfunction

  // Number of active entries: d factorial, limited to the table depth
  function automatic logic [NACT_W-1:0] active_count(input logic [DIM_W-1:0] d);
    int f;
    f = 1;
    for (int k = 2; k <= MAX_DIMENSION; k++) begin
      if (k <= int'(d)) f = f * k;
    end
    if (f > TABLE_DEPTH) f = TABLE_DEPTH;
    return NACT_W'(f);
  endfunction

endpackage
`default_nettype wire

### rtl/ophist_cell.sv
// One table entry of the chain: symbol entry, match counter and a stage register.
`default_nettype none
module ophist_cell (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              adv,
  input  wire [ophist_pkg::CELL_W-1:0]     cell_idx,
  input  ophist_pkg::chain_ctl_t           ctl,
  input  ophist_pkg::item_t                item_in,
  output ophist_pkg::item_t                item_out
);

  logic [ophist_pkg::PAT_W-1:0]      entry_r, entry_nxt;
  logic [ophist_pkg::COUNT_BITS-1:0] count_r, count_nxt;
  ophist_pkg::item_t                 item_r, item_nxt;

  logic hit;
  logic active;
  logic match;

  // Decode which transaction touches this entry
  assign hit    = item_in.valid &&
                  (ophist_pkg::CMP_W'(item_in.idx) == ophist_pkg::CMP_W'(cell_idx));
  assign active = (ophist_pkg::NACT_W'(cell_idx) < ctl.nact);
  assign match  = (((item_in.word ^ entry_r) & ctl.mask) == '0);

  // Update entry and counter, pass the transaction on
  always_comb begin
    entry_nxt = entry_r;
    count_nxt = count_r;
    item_nxt  = item_r;
    if (adv) begin
      item_nxt = item_in;
      if (item_in.valid) begin
        case (item_in.op)
          ophist_pkg::OP_LOAD: begin
            if (hit) entry_nxt = item_in.word;
          end
          ophist_pkg::OP_COUNT: begin
            if (active && match && (count_r != '1)) count_nxt = count_r + 1'b1;
          end
          ophist_pkg::OP_READ: begin
            if (hit) item_nxt.cnt = count_r;
          end
          ophist_pkg::OP_CLEAR: begin
            count_nxt = '0;
          end
          default: begin
            count_nxt = count_r;
          end
        endcase
      end
    end
  end

  // Symbol entry holds no reset value
  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      item_r  <= '0;
    end else begin
      count_r <= count_nxt;
      item_r  <= item_nxt;
    end
  end

  assign item_out = item_r;

endmodule
`default_nettype wire

### rtl/ophist_div.sv
// Bit-serial frequency divider: count * 2^16 / total, limited to 2^16.
`default_nettype none
module ophist_div (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  start,
  input  wire [ophist_pkg::ENTRY_W-1:0]        idx,
  input  wire [ophist_pkg::COUNT_BITS-1:0]     cnt,
  input  wire [ophist_pkg::COUNT_BITS-1:0]     total,
  input  wire                                  take,
  output logic                                 busy,
  output logic                                 done,
  output ophist_pkg::rd_res_t                  res
);

  localparam int CB = ophist_pkg::COUNT_BITS;

  ophist_pkg::div_state_t state_r, state_nxt;

  logic [CB-1:0]                     rem_r, rem_nxt;
  logic [CB-1:0]                     den_r, den_nxt;
  logic [ophist_pkg::FRAC_BITS-1:0]  q_r, q_nxt;
  logic [ophist_pkg::STEP_W-1:0]     step_r, step_nxt;
  logic [ophist_pkg::ENTRY_W-1:0]    idx_r, idx_nxt;
  logic [CB-1:0]                     cnt_r, cnt_nxt;
  logic                              sat_r, sat_nxt;
  logic                              none_r, none_nxt;

  logic [CB:0] rem_dbl;
  logic [CB:0] rem_sub;

  // One restoring step per cycle
  assign rem_dbl = {rem_r, 1'b0};
  assign rem_sub = rem_dbl - {1'b0, den_r};

  always_comb begin
    state_nxt = state_r;
    rem_nxt   = rem_r;
    den_nxt   = den_r;
    q_nxt     = q_r;
    step_nxt  = step_r;
    idx_nxt   = idx_r;
    cnt_nxt   = cnt_r;
    sat_nxt   = sat_r;
    none_nxt  = none_r;
    case (state_r)
      ophist_pkg::DIV_IDLE: begin
        if (start) begin
          idx_nxt  = idx;
          cnt_nxt  = cnt;
          den_nxt  = total;
          rem_nxt  = cnt;
          q_nxt    = '0;
          step_nxt = '0;
          none_nxt = (total == '0);
          sat_nxt  = (total != '0) && (cnt >= total);
          // No windows or a full share need no iterations
          if ((total == '0) || (cnt >= total)) state_nxt = ophist_pkg::DIV_DONE;
          else state_nxt = ophist_pkg::DIV_RUN;
        end
      end
      ophist_pkg::DIV_RUN: begin
        if (rem_dbl >= {1'b0, den_r}) begin
          rem_nxt = rem_sub[CB-1:0];
          q_nxt   = {q_r[ophist_pkg::FRAC_BITS-2:0], 1'b1};
        end else begin
          rem_nxt = rem_dbl[CB-1:0];
          q_nxt   = {q_r[ophist_pkg::FRAC_BITS-2:0], 1'b0};
        end
        step_nxt = step_r + 1'b1;
        if (step_r == ophist_pkg::STEP_W'(ophist_pkg::FRAC_BITS - 1)) begin
          state_nxt = ophist_pkg::DIV_DONE;
        end
      end
      ophist_pkg::DIV_DONE: begin
        if (take) state_nxt = ophist_pkg::DIV_IDLE;
      end
      default: begin
        state_nxt = ophist_pkg::DIV_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ophist_pkg::DIV_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    den_r  <= den_nxt;
    q_r    <= q_nxt;
    step_r <= step_nxt;
    idx_r  <= idx_nxt;
    cnt_r  <= cnt_nxt;
    sat_r  <= sat_nxt;
    none_r <= none_nxt;
  end

  assign busy     = (state_r != ophist_pkg::DIV_IDLE);
  assign done     = (state_r == ophist_pkg::DIV_DONE);
  assign res.idx  = idx_r;
  assign res.cnt  = ophist_pkg::MATCH_W'(cnt_r);
  assign res.freq = none_r ? '0 :
                    (sat_r ? ophist_pkg::FREQ_W'(1) << ophist_pkg::FRAC_BITS
                           : {1'b0, q_r});
  assign res.none = none_r;

endmodule
`default_nettype wire

### rtl/ordinal_pattern_histogram_top.sv
// A read transaction passes TABLE_DEPTH chain stages, then the divider and the output
//   register; load, count and clear give no result.
// Throughput: one transaction per cycle through the cell chain; a read at the chain tail
//   holds the whole chain until the 16-step bit-serial divider has handed on its last result.
// Reset: counters and total cleared at once, dimension 3; symbol entries stay
//   undefined until loaded.
`default_nettype none
module ordinal_pattern_histogram_top (
  input  wire                                clk,
  input  wire                                rst_n,
  // Input transactions
  input  wire                                in_valid,
  output logic                               in_stall,
  input  wire [ophist_pkg::OP_W-1:0]         in_op,
  input  wire [ophist_pkg::ENTRY_W-1:0]      in_entry_index,
  input  wire [ophist_pkg::PAT_W-1:0]        in_pattern_word,
  // Result transactions
  output logic                               out_valid,
  input  wire                                out_stall,
  output logic [ophist_pkg::ENTRY_W-1:0]     out_read_index,
  output logic [ophist_pkg::MATCH_W-1:0]     out_match_count,
  output logic [ophist_pkg::FREQ_W-1:0]      out_frequency,
  output logic                               out_no_windows,
  // Dimension register write
  input  wire                                cfg_valid,
  output logic                               cfg_ready,
  input  wire [ophist_pkg::DIM_W-1:0]        cfg_data
);

  localparam int DEPTH = ophist_pkg::TABLE_DEPTH;

  ophist_pkg::chain_ctl_t            ctl_r, ctl_nxt;
  logic [ophist_pkg::COUNT_BITS-1:0] total_r, total_nxt;
  logic                              out_valid_r, out_valid_nxt;
  ophist_pkg::rd_res_t               out_r, out_nxt;

  ophist_pkg::item_t chain [0:DEPTH];
  ophist_pkg::item_t tail;

  logic                adv;
  logic                div_start;
  logic                div_busy;
  logic                div_done;
  logic                out_load;
  ophist_pkg::rd_res_t div_res;

  // Hold the whole chain while a read waits for the divider
  assign tail      = chain[DEPTH];
  assign adv       = !(tail.valid && (tail.op == ophist_pkg::OP_READ) && div_busy);
  assign in_stall  = !adv;
  assign cfg_ready = 1'b1;

  // Chain head
  assign chain[0] = {in_valid, ophist_pkg::op_t'(in_op), in_entry_index, in_pattern_word,
                     ophist_pkg::COUNT_BITS'(0)};

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    ophist_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .adv      (adv),
      .cell_idx (ophist_pkg::CELL_W'(g)),
      .ctl      (ctl_r),
      .item_in  (chain[g]),
      .item_out (chain[g+1])
    );
  end

  // Dimension register kept as element mask and active entry count
  always_comb begin
    ctl_nxt = ctl_r;
    if (cfg_valid && cfg_ready) begin
      ctl_nxt.mask = ophist_pkg::elem_mask(ophist_pkg::eff_dim(cfg_data));
      ctl_nxt.nact = ophist_pkg::active_count(ophist_pkg::eff_dim(cfg_data));
    end
  end

  // Total window count updated as transactions leave the chain
  always_comb begin
    total_nxt = total_r;
    if (adv && tail.valid) begin
      case (tail.op)
        ophist_pkg::OP_COUNT: begin
          if (total_r != '1) total_nxt = total_r + 1'b1;
        end
        ophist_pkg::OP_CLEAR: begin
          total_nxt = '0;
        end
        default: begin
          total_nxt = total_r;
        end
      endcase
    end
  end

  assign div_start = adv && tail.valid && (tail.op == ophist_pkg::OP_READ);

  ophist_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .idx   (tail.idx),
    .cnt   (tail.cnt),
    .total (total_r),
    .take  (out_load),
    .busy  (div_busy),
    .done  (div_done),
    .res   (div_res)
  );

  // Output register: load when empty or being drained
  assign out_load = div_done && (!out_valid_r || !out_stall);

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_nxt       = div_res;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.mask  <= ophist_pkg::elem_mask(ophist_pkg::eff_dim(ophist_pkg::DIM_RESET));
      ctl_r.nact  <= ophist_pkg::active_count(ophist_pkg::eff_dim(ophist_pkg::DIM_RESET));
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      ctl_r       <= ctl_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_read_index  = out_r.idx;
  assign out_match_count = out_r.cnt;
  assign out_frequency   = out_r.freq;
  assign out_no_windows  = out_r.none;

  // Checks
  a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  a_clear_total: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && tail.valid && (tail.op == ophist_pkg::OP_CLEAR)) |=> (total_r == '0))
    else $error("total not cleared");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> $stable(out_r))
    else $error("pending result overwritten");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (tail.valid && (tail.op == ophist_pkg::OP_READ)))
    else $error("chain held without a waiting read");

endmodule
`default_nettype wire
